// ----- src/usv_pkg.sv -----
// Shared types and constants of the UTF-8 string validator.
`timescale 1ns / 1ps
package usv_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 13;
    localparam int CP_W    = 21;

    // Byte class limits
    localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;
    localparam logic [BYTE_W-1:0] DEL_CODE   = 8'h7f;
    localparam logic [BYTE_W-1:0] ASCII_END  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'hc2;
    localparam logic [BYTE_W-1:0] LEAD2_MAX  = 8'hdf;
    localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD3_MAX  = 8'hef;
    localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD4_MAX  = 8'hf4;
    localparam logic [1:0]        CONT_TAG   = 2'b10;

    // Code point limits
    localparam logic [CP_W-1:0] CP_MAX     = 21'h10ffff;
    localparam logic [CP_W-1:0] SURR_MIN   = 21'h00d800;
    localparam logic [CP_W-1:0] SURR_MAX   = 21'h00dfff;
    localparam logic [CP_W-1:0] MIN_2BYTE  = 21'h000080;
    localparam logic [CP_W-1:0] MIN_3BYTE  = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4BYTE  = 21'h010000;

    // Length limits
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 13'd8191;
    localparam logic [COUNT_W-1:0] MAX_LEN_RESET  = 13'd4096;

    // Continuation counts of a sequence
    localparam logic [1:0] SEQ_NONE = 2'd0;
    localparam logic [1:0] SEQ_2    = 2'd1;
    localparam logic [1:0] SEQ_3    = 2'd2;
    localparam logic [1:0] SEQ_4    = 2'd3;

    // Queue between classifier and checker
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One classified byte
    typedef struct packed {
        logic       last;       // final byte of the string
        logic       lead_err;   // not allowed where a lead byte is expected
        logic [1:0] lead_len;   // continuations that follow this lead
        logic [4:0] lead_bits;  // payload bits of the lead byte
        logic       cont_err;   // top bits are not a continuation tag
        logic [5:0] cont_bits;  // payload bits of a continuation byte
    } t_item;

endpackage

// ----- src/usv_front.sv -----
// Front end: classifies each incoming byte both as a lead and as a continuation.
`timescale 1ns / 1ps
module usv_front
    import usv_pkg::*;
(
    input  logic              i_in_valid,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_push_ready,
    output logic              o_in_ready,
    output logic              o_push_valid,
    output t_item             o_push_item
);

    logic       w_is_lead2;
    logic       w_is_lead3;
    logic       w_is_lead4;
    logic       w_bad_ascii;
    logic       w_bad_high;

    // Decode lead byte ranges
    assign w_is_lead2  = (i_data_byte >= LEAD2_MIN) && (i_data_byte <= LEAD2_MAX);
    assign w_is_lead3  = (i_data_byte >= LEAD3_MIN) && (i_data_byte <= LEAD3_MAX);
    assign w_is_lead4  = (i_data_byte >= LEAD4_MIN) && (i_data_byte <= LEAD4_MAX);
    assign w_bad_ascii = (i_data_byte < CTRL_LIMIT) || (i_data_byte == DEL_CODE);
    assign w_bad_high  = (i_data_byte >= ASCII_END) && !w_is_lead2 && !w_is_lead3
                         && !w_is_lead4;

    // Build the classified request
    always_comb begin
        o_push_item           = '0;
        o_push_item.last      = i_last_byte;
        o_push_item.lead_err  = w_bad_ascii || w_bad_high;
        o_push_item.cont_err  = (i_data_byte[7:6] != CONT_TAG);
        o_push_item.cont_bits = i_data_byte[5:0];
        if (w_is_lead2) begin
            o_push_item.lead_len  = SEQ_2;
            o_push_item.lead_bits = i_data_byte[4:0];
        end else if (w_is_lead3) begin
            o_push_item.lead_len  = SEQ_3;
            o_push_item.lead_bits = {1'b0, i_data_byte[3:0]};
        end else if (w_is_lead4) begin
            o_push_item.lead_len  = SEQ_4;
            o_push_item.lead_bits = {2'b00, i_data_byte[2:0]};
        end else begin
            o_push_item.lead_len  = SEQ_NONE;
            o_push_item.lead_bits = '0;
        end
    end

    assign o_push_valid = i_in_valid;
    assign o_in_ready   = i_push_ready;

endmodule

// ----- src/usv_queue.sv -----
// Short register queue between the classifier and the checker.
`timescale 1ns / 1ps
module usv_queue
    import usv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    input  t_item i_push_item,
    output logic  o_push_ready,
    output logic  o_pop_valid,
    output t_item o_pop_item,
    input  logic  i_pop_ready
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_count != QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    // Store the incoming request
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ----- src/usv_back.sv -----
// Back end: tracks the sequence state of the string and registers the verdict.
`timescale 1ns / 1ps
module usv_back
    import usv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [COUNT_W-1:0] i_max_length,
    input  logic               i_pop_valid,
    input  t_item              i_pop_item,
    output logic               o_pop_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_string_valid
);

    logic [COUNT_W-1:0] r_byte_count;
    logic [1:0]         r_pending;
    logic [1:0]         r_seq_len;
    logic [CP_W-1:0]    r_code_point;
    logic               r_error;
    logic               r_out_valid;
    logic               r_string_valid;

    logic [COUNT_W-1:0] n_byte_count;
    logic [1:0]         n_pending;
    logic [1:0]         n_seq_len;
    logic [CP_W-1:0]    n_code_point;
    logic               n_error;
    logic               n_string_valid;

    logic [COUNT_W:0]   w_next_count;
    logic               w_pop;

    // Take a byte unless a final byte would meet a full output register
    assign o_pop_ready = !i_pop_item.last || !r_out_valid || i_out_ready;
    assign w_pop       = i_pop_valid && o_pop_ready;

    assign w_next_count = {1'b0, r_byte_count} + (COUNT_W+1)'(1);

    // Update the string state for one byte
    always_comb begin
        n_error        = r_error;
        n_pending      = r_pending;
        n_seq_len      = r_seq_len;
        n_code_point   = r_code_point;
        n_string_valid = 1'b0;

        if (w_next_count > {1'b0, i_max_length}) begin
            n_error = 1'b1;
        end
        n_byte_count = (w_next_count > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                          : w_next_count[COUNT_W-1:0];

        if (r_pending == SEQ_NONE) begin
            // Lead byte expected
            if (i_pop_item.lead_err) begin
                n_error = 1'b1;
            end else if (i_pop_item.lead_len != SEQ_NONE) begin
                n_pending    = i_pop_item.lead_len;
                n_seq_len    = i_pop_item.lead_len;
                n_code_point = {{(CP_W-5){1'b0}}, i_pop_item.lead_bits};
            end
        end else begin
            // Continuation byte expected
            if (i_pop_item.cont_err) begin
                n_error = 1'b1;
            end
            n_code_point = {r_code_point[CP_W-7:0], i_pop_item.cont_bits};
            n_pending    = r_pending - 2'd1;
            if (n_pending == SEQ_NONE) begin
                if ((r_seq_len == SEQ_2 && n_code_point < MIN_2BYTE) ||
                    (r_seq_len == SEQ_3 && n_code_point < MIN_3BYTE) ||
                    (r_seq_len == SEQ_4 && n_code_point < MIN_4BYTE) ||
                    (n_code_point > CP_MAX) ||
                    (n_code_point >= SURR_MIN && n_code_point <= SURR_MAX)) begin
                    n_error = 1'b1;
                end
            end
        end

        // Close the string on its final byte
        if (i_pop_item.last) begin
            if (n_pending != SEQ_NONE) begin
                n_error = 1'b1;
            end
            n_string_valid = !n_error;
            n_byte_count   = '0;
            n_pending      = SEQ_NONE;
            n_seq_len      = SEQ_NONE;
            n_code_point   = '0;
            n_error        = 1'b0;
        end
    end

    // Hold the string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_pending    <= SEQ_NONE;
            r_seq_len    <= SEQ_NONE;
            r_code_point <= '0;
            r_error      <= 1'b0;
        end else if (w_pop) begin
            r_byte_count <= n_byte_count;
            r_pending    <= n_pending;
            r_seq_len    <= n_seq_len;
            r_code_point <= n_code_point;
            r_error      <= n_error;
        end
    end

    // Hold the verdict until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop && i_pop_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && i_pop_item.last) begin
            r_string_valid <= n_string_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_string_valid = r_string_valid;

endmodule

// ----- src/utf8_string_validator_core.sv -----
// Top level of the UTF-8 string validator.
`timescale 1ns / 1ps
// The block takes one string byte per cycle while o_in_ready is high and
// checks it for well-formed UTF-8 text without NUL, control bytes below 0x20
// or DEL, and with a length no larger than max_length (reset 4096). Mark the
// final byte with i_last_byte; once that byte has passed the queue and the
// checker's output register, o_string_valid shows the verdict for the whole
// string and holds until o_out_valid meets i_out_ready.
// Other bytes give no result. A two-entry queue between the byte classifier
// and the checker absorbs a stalled output. Write max_length only while no
// string is in flight.
module utf8_string_validator_core
    import usv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic               i_last_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_string_valid,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [COUNT_W-1:0] i_cfg_max_length
);

    logic [COUNT_W-1:0] r_max_length;
    logic               w_push_valid;
    logic               w_push_ready;
    t_item              w_push_item;
    logic               w_pop_valid;
    logic               w_pop_ready;
    t_item              w_pop_item;

    // Length limit register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LEN_RESET;
        end else if (i_cfg_valid) begin
            r_max_length <= i_cfg_max_length;
        end
    end

    usv_front u_front (
        .i_in_valid   (i_in_valid),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_push_ready (w_push_ready),
        .o_in_ready   (o_in_ready),
        .o_push_valid (w_push_valid),
        .o_push_item  (w_push_item)
    );

    usv_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_item  (w_push_item),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_item   (w_pop_item),
        .i_pop_ready  (w_pop_ready)
    );

    usv_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_max_length   (r_max_length),
        .i_pop_valid    (w_pop_valid),
        .i_pop_item     (w_pop_item),
        .o_pop_ready    (w_pop_ready),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_string_valid (o_string_valid)
    );

    // A verdict appears only after a final byte left the queue
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_pop_valid && w_pop_ready && w_pop_item.last))
        else $error("verdict without a final byte");

    // A final byte never overwrites a verdict that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop_valid && w_pop_ready && w_pop_item.last) |-> (!o_out_valid || i_out_ready))
        else $error("verdict overwritten");

    // Input stalls only while the queue holds bytes
    a_stall_needs_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> w_pop_valid)
        else $error("input stalled with empty queue");

endmodule
